// File: sv/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, off while reset is held.
`define LOBM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define LOBM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/lobm_pkg.sv
// Types, codes and helpers of the order book matcher.
package lobm_pkg;

  localparam int unsigned DW = 32;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_MARKET = 2'd1;
  localparam logic [1:0] ACT_CANCEL = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam logic KIND_TRADE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  typedef struct packed {
    logic [DW-1:0] price;
    logic [DW-1:0] qty;
    logic [DW-1:0] id;
  } entry_t;

  typedef struct packed {
    logic          kind;
    logic [DW-1:0] trade_price;
    logic [DW-1:0] trade_qty;
    logic [DW-1:0] buyer_id;
    logic [DW-1:0] seller_id;
    logic [1:0]    status;
    logic [DW-1:0] remaining_qty;
    logic          found_side;
    logic          last;
  } result_t;

  function automatic result_t mk_trade(input logic [DW-1:0] pr, input logic [DW-1:0] q,
                                       input logic [DW-1:0] b, input logic [DW-1:0] s);
    result_t r;
    r.kind          = KIND_TRADE;
    r.trade_price   = pr;
    r.trade_qty     = q;
    r.buyer_id      = b;
    r.seller_id     = s;
    r.status        = ST_OK;
    r.remaining_qty = '0;
    r.found_side    = 1'b0;
    r.last          = 1'b0;
    return r;
  endfunction

  function automatic result_t mk_done(input logic [1:0] st, input logic [DW-1:0] rem,
                                      input logic fs);
    result_t r;
    r.kind          = KIND_DONE;
    r.trade_price   = '0;
    r.trade_qty     = '0;
    r.buyer_id      = '0;
    r.seller_id     = '0;
    r.status        = st;
    r.remaining_qty = rem;
    r.found_side    = fs;
    r.last          = 1'b1;
    return r;
  endfunction

endpackage

// File: sv/lobm_if.sv
// Request and result channel interfaces.
interface lobm_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic                     side;
  logic [lobm_pkg::DW-1:0]  limit_price;
  logic [lobm_pkg::DW-1:0]  quantity;
  logic [lobm_pkg::DW-1:0]  order_id;
  modport source (output valid, action, side, limit_price, quantity, order_id, input ready);
  modport sink (input valid, action, side, limit_price, quantity, order_id, output ready);
endinterface

interface lobm_out_if;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [lobm_pkg::DW-1:0]  trade_price;
  logic [lobm_pkg::DW-1:0]  trade_qty;
  logic [lobm_pkg::DW-1:0]  buyer_id;
  logic [lobm_pkg::DW-1:0]  seller_id;
  logic [1:0]               status;
  logic [lobm_pkg::DW-1:0]  remaining_qty;
  logic                     found_side;
  logic                     last;
  modport source (output valid, kind, trade_price, trade_qty, buyer_id, seller_id, status,
                  remaining_qty, found_side, last, input ready);
  modport sink (input valid, kind, trade_price, trade_qty, buyer_id, seller_id, status,
                remaining_qty, found_side, last, output ready);
endinterface

// File: sv/lobm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lobm_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/limit_order_book_matcher.sv
// Top level: price-time priority order book with a RAM per side and a sequencer.
//
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid/ready   | action, side, limit_price, quantity, order_id
//  out_ch  | out | valid/ready   | kind, trade fields, status, remaining_qty, found_side, last
//
// One request at a time. Each book sits in a RAM used as a ring (head pointer + count),
// so removing the best entry costs nothing but the pointer.
// Insert reads each resting entry it passes from the tail and shifts it up one slot.
// Each fill reads both heads, then compares and writes back. Cancel reads each entry
// scanned, then reads and writes each later entry to shift it down; a completion
// report ends every request. RAM read data is registered, so each step is split into
// a read state and a compare or write state.
// rst_n (synchronous) empties both books by clearing counts; RAM contents are not cleared.
// A stalled out_ch holds the sequencer at the next report; in_ch is ready only when idle.
module limit_order_book_matcher #(
  parameter int unsigned BOOK_DEPTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  lobm_in_if.sink    in_ch,
  lobm_out_if.source out_ch
);
  localparam int unsigned AW = $clog2(BOOK_DEPTH);
  localparam int unsigned CW = $clog2(BOOK_DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned DW = lobm_pkg::DW;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_INS_RD  = 10'b0000000010,
    S_INS_CMP = 10'b0000000100,
    S_M_RD    = 10'b0000001000,
    S_M_CMP   = 10'b0000010000,
    S_C_RD    = 10'b0000100000,
    S_C_CMP   = 10'b0001000000,
    S_RM_RD   = 10'b0010000000,
    S_RM_WR   = 10'b0100000000,
    S_DONE    = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // per book: index 0 bids, index 1 asks
  logic [CW-1:0] cnt_r  [2];
  logic [CW-1:0] cnt_nxt [2];
  logic [AW-1:0] head_r [2];
  logic [AW-1:0] head_nxt [2];

  logic                we    [2];
  logic [AW-1:0]       waddr [2];
  lobm_pkg::entry_t    wdata [2];
  logic [AW-1:0]       raddr [2];
  lobm_pkg::entry_t    rd    [2];

  // latched request
  logic          side_r, side_nxt;
  logic [DW-1:0] price_r, price_nxt;
  logic [DW-1:0] oid_r, oid_nxt;
  logic          mkt_r, mkt_nxt;
  logic          bk_r, bk_nxt;       // book being inserted, scanned or compacted
  logic [CW-1:0] idx_r, idx_nxt;     // logical position in that book
  logic [DW-1:0] rem_r, rem_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          fs_r, fs_nxt;

  lobm_pkg::result_t res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              can_emit;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] i);
    logic [SW-1:0] s;
    s = SW'(head) + SW'(i);
    if (s >= SW'(BOOK_DEPTH)) begin
      s = s - SW'(BOOK_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
    return (p == AW'(BOOK_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  for (genvar k = 0; k < 2; k++) begin : g_book
    lobm_ram #(
      .WIDTH ($bits(lobm_pkg::entry_t)),
      .DEPTH (BOOK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (we[k]),
      .waddr (waddr[k]),
      .wdata (wdata[k]),
      .raddr (raddr[k]),
      .rdata (rd[k])
    );
  end

  assign can_emit = !out_valid_r || out_ch.ready;

  always_comb begin
    logic          ahead;
    logic          opp;
    logic [DW-1:0] f;
    logic [DW-1:0] bq;
    logic [DW-1:0] aq;
    lobm_pkg::entry_t e;

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    head_nxt      = head_r;
    side_nxt      = side_r;
    price_nxt     = price_r;
    oid_nxt       = oid_r;
    mkt_nxt       = mkt_r;
    bk_nxt        = bk_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    status_nxt    = status_r;
    fs_nxt        = fs_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    for (int k = 0; k < 2; k++) begin
      we[k]    = 1'b0;
      waddr[k] = head_r[k];
      wdata[k] = rd[k];
      raddr[k] = head_r[k];
    end
    ahead  = 1'b0;
    opp    = ~side_r;
    f      = '0;
    bq     = rd[0].qty;
    aq     = rd[1].qty;
    e      = rd[opp];

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          side_nxt   = in_ch.side;
          price_nxt  = in_ch.limit_price;
          oid_nxt    = in_ch.order_id;
          rem_nxt    = in_ch.quantity;
          status_nxt = lobm_pkg::ST_OK;
          fs_nxt     = 1'b0;
          idx_nxt    = '0;
          mkt_nxt    = 1'b0;
          case (in_ch.action)
            lobm_pkg::ACT_ADD: begin
              if (in_ch.quantity == '0) begin
                state_nxt = S_DONE;
              end else if (cnt_r[in_ch.side] >= CW'(BOOK_DEPTH)) begin
                status_nxt = lobm_pkg::ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                bk_nxt    = in_ch.side;
                idx_nxt   = cnt_r[in_ch.side];
                state_nxt = S_INS_RD;
              end
            end
            lobm_pkg::ACT_MARKET: begin
              mkt_nxt   = 1'b1;
              state_nxt = S_M_RD;
            end
            lobm_pkg::ACT_CANCEL: begin
              rem_nxt   = '0;
              bk_nxt    = lobm_pkg::SIDE_SELL;   // asks are searched first
              state_nxt = S_C_RD;
            end
            default: begin
              rem_nxt   = '0;
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // walk from the tail, moving each worse entry up one slot
      S_INS_RD: begin
        if (idx_r == '0) begin
          we[bk_r]    = 1'b1;
          waddr[bk_r] = phys(head_r[bk_r], '0);
          wdata[bk_r] = '{price: price_r, qty: rem_r, id: oid_r};
          cnt_nxt[bk_r] = cnt_r[bk_r] + 1'b1;
          state_nxt   = S_M_RD;
        end else begin
          raddr[bk_r] = phys(head_r[bk_r], idx_r - 1'b1);
          state_nxt   = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        e = rd[bk_r];
        if (bk_r == lobm_pkg::SIDE_BUY) begin
          ahead = e.price > price_r;
        end else begin
          ahead = e.price < price_r;
        end
        ahead = ahead || (e.price == price_r && e.id <= oid_r);
        we[bk_r]    = 1'b1;
        waddr[bk_r] = phys(head_r[bk_r], idx_r);
        if (ahead) begin
          wdata[bk_r]   = '{price: price_r, qty: rem_r, id: oid_r};
          cnt_nxt[bk_r] = cnt_r[bk_r] + 1'b1;
          state_nxt     = S_M_RD;
        end else begin
          wdata[bk_r] = e;
          idx_nxt     = idx_r - 1'b1;
          state_nxt   = S_INS_RD;
        end
      end

      // both heads are read; writes from the last fill have already landed
      S_M_RD: begin
        if (mkt_r) begin
          state_nxt = (rem_r != '0 && cnt_r[opp] != '0) ? S_M_CMP : S_DONE;
        end else begin
          state_nxt = (cnt_r[0] != '0 && cnt_r[1] != '0) ? S_M_CMP : S_DONE;
        end
      end

      S_M_CMP: begin
        if (!mkt_r) begin
          if (rd[0].price < rd[1].price) begin
            state_nxt = S_DONE;
          end else if (can_emit) begin
            f             = (bq < aq) ? bq : aq;
            res_nxt       = lobm_pkg::mk_trade(rd[1].price, f, rd[0].id, rd[1].id);
            out_valid_nxt = 1'b1;
            rem_nxt       = (rem_r >= f) ? rem_r - f : '0;
            for (int k = 0; k < 2; k++) begin
              if (rd[k].qty == f) begin
                head_nxt[k] = inc_ptr(head_r[k]);
                cnt_nxt[k]  = cnt_r[k] - 1'b1;
              end else begin
                we[k]        = 1'b1;
                wdata[k].qty = rd[k].qty - f;
              end
            end
            state_nxt = S_M_RD;
          end
        end else if (can_emit) begin
          f = (rem_r < e.qty) ? rem_r : e.qty;
          if (side_r == lobm_pkg::SIDE_BUY) begin
            res_nxt = lobm_pkg::mk_trade(e.price, f, oid_r, e.id);
          end else begin
            res_nxt = lobm_pkg::mk_trade(e.price, f, e.id, oid_r);
          end
          out_valid_nxt = 1'b1;
          rem_nxt       = rem_r - f;
          if (e.qty == f) begin
            head_nxt[opp] = inc_ptr(head_r[opp]);
            cnt_nxt[opp]  = cnt_r[opp] - 1'b1;
          end else begin
            we[opp]        = 1'b1;
            wdata[opp].qty = e.qty - f;
          end
          state_nxt = S_M_RD;
        end
      end

      S_C_RD: begin
        if (idx_r < cnt_r[bk_r]) begin
          raddr[bk_r] = phys(head_r[bk_r], idx_r);
          state_nxt   = S_C_CMP;
        end else if (bk_r == lobm_pkg::SIDE_SELL) begin
          bk_nxt  = lobm_pkg::SIDE_BUY;
          idx_nxt = '0;
        end else begin
          status_nxt = lobm_pkg::ST_NOTFOUND;
          state_nxt  = S_DONE;
        end
      end

      S_C_CMP: begin
        if (rd[bk_r].id == oid_r) begin
          fs_nxt    = bk_r;
          state_nxt = S_RM_RD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_C_RD;
        end
      end

      // close the gap: entry idx+1 moves to idx
      S_RM_RD: begin
        if (SW'(idx_r) + 1'b1 < SW'(cnt_r[bk_r])) begin
          raddr[bk_r] = phys(head_r[bk_r], idx_r + 1'b1);
          state_nxt   = S_RM_WR;
        end else begin
          cnt_nxt[bk_r] = cnt_r[bk_r] - 1'b1;
          state_nxt     = S_DONE;
        end
      end

      S_RM_WR: begin
        we[bk_r]    = 1'b1;
        waddr[bk_r] = phys(head_r[bk_r], idx_r);
        wdata[bk_r] = rd[bk_r];
        idx_nxt     = idx_r + 1'b1;
        state_nxt   = S_RM_RD;
      end

      S_DONE: begin
        if (can_emit) begin
          res_nxt       = lobm_pkg::mk_done(status_r, rem_r, fs_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '{default: '0};
      head_r      <= '{default: '0};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    side_r   <= side_nxt;
    price_r  <= price_nxt;
    oid_r    <= oid_nxt;
    mkt_r    <= mkt_nxt;
    bk_r     <= bk_nxt;
    idx_r    <= idx_nxt;
    rem_r    <= rem_nxt;
    status_r <= status_nxt;
    fs_r     <= fs_nxt;
    res_r    <= res_nxt;
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = res_r.kind;
  assign out_ch.trade_price   = res_r.trade_price;
  assign out_ch.trade_qty     = res_r.trade_qty;
  assign out_ch.buyer_id      = res_r.buyer_id;
  assign out_ch.seller_id     = res_r.seller_id;
  assign out_ch.status        = res_r.status;
  assign out_ch.remaining_qty = res_r.remaining_qty;
  assign out_ch.found_side    = res_r.found_side;
  assign out_ch.last          = res_r.last;
endmodule

// File: sv/lobm_checker.sv
// Port-level checker for the order book matcher, bound to the top level.
`include "assert_macros.svh"

module lobm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic       out_last,
  input logic [1:0] out_status,
  input logic [31:0] out_remaining_qty
);
  `LOBM_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_last), "result dropped while stalled")
  `LOBM_ASSERT(a_last_kind, clk, rst_n, out_valid |-> out_last == out_kind, "last flag disagrees with kind")
  `LOBM_ASSERT(a_trade_clean, clk, rst_n, out_valid && !out_kind |-> out_status == 2'd0 && out_remaining_qty == '0, "trade report carries completion fields")
  `LOBM_ASSERT(a_one_at_a_time, clk, rst_n, in_valid && in_ready |=> !in_ready, "second request taken while busy")
endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_kind          (out_ch.kind),
  .out_last          (out_ch.last),
  .out_status        (out_ch.status),
  .out_remaining_qty (out_ch.remaining_qty)
);

// File: verif/tb_limit_order_book_matcher.sv
// Testbench for the order book matcher: directed and random requests checked against a book model.
`timescale 1ns / 1ps

module tb_limit_order_book_matcher;

  localparam int DEPTH = 16;
  localparam int unsigned DW = lobm_pkg::DW;
  localparam logic [1:0] ACT_UNUSED = 2'd3;   // action code with no meaning

  typedef struct packed {
    logic [1:0]    action;
    logic          side;
    logic [DW-1:0] limit_price;
    logic [DW-1:0] quantity;
    logic [DW-1:0] order_id;
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  lobm_in_if  req_ch ();
  lobm_out_if res_ch ();

  limit_order_book_matcher #(.BOOK_DEPTH(DEPTH)) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_ch.sink),
    .out_ch(res_ch.source)
  );

  // Model books: index 0 is the best entry on each side.
  lobm_pkg::entry_t bids[$];
  lobm_pkg::entry_t asks[$];

  request_t          pending_reqs[$];
  lobm_pkg::result_t expected_results[$];
  int                fail_count = 0;

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("ERROR %0t: %s", $realtime, what);
  endtask

  function automatic void add_expected(input lobm_pkg::result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void add_request(input request_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // Price-time insert: bids descending, asks ascending, equal price sorted by id,
  // a new order goes after an existing order with equal price and id.
  function automatic void book_insert(input logic sd, input lobm_pkg::entry_t e);
    int pos;
    bit goes_after;
    pos = 0;
    if (sd == lobm_pkg::SIDE_BUY) begin
      while (pos < bids.size()) begin
        goes_after = bids[pos].price > e.price ||
                     (bids[pos].price == e.price && bids[pos].id <= e.id);
        if (!goes_after) break;
        pos++;
      end
      bids.insert(pos, e);
    end else begin
      while (pos < asks.size()) begin
        goes_after = asks[pos].price < e.price ||
                     (asks[pos].price == e.price && asks[pos].id <= e.id);
        if (!goes_after) break;
        pos++;
      end
      asks.insert(pos, e);
    end
  endfunction

  function automatic lobm_pkg::result_t trade_item(input logic [DW-1:0] pr,
                                                   input logic [DW-1:0] q,
                                                   input logic [DW-1:0] b,
                                                   input logic [DW-1:0] s);
    lobm_pkg::result_t r;
    r = '0;
    r.kind = lobm_pkg::KIND_TRADE;
    r.trade_price = pr;
    r.trade_qty = q;
    r.buyer_id = b;
    r.seller_id = s;
    return r;
  endfunction

  function automatic lobm_pkg::result_t done_item(input logic [1:0] st,
                                                  input logic [DW-1:0] rem,
                                                  input logic fs);
    lobm_pkg::result_t r;
    r = '0;
    r.kind = lobm_pkg::KIND_DONE;
    r.status = st;
    r.remaining_qty = rem;
    r.found_side = fs;
    r.last = 1'b1;
    return r;
  endfunction

  // Apply one request to the model books and queue the reports it causes.
  function automatic void match_request(input request_t rq);
    logic [DW-1:0] rem, fill;
    lobm_pkg::entry_t e;
    int pos;
    rem = rq.quantity;
    case (rq.action)
      lobm_pkg::ACT_ADD: begin
        if (rq.quantity == 0) begin
          add_expected(done_item(lobm_pkg::ST_OK, '0, 1'b0));
        end else if ((rq.side == lobm_pkg::SIDE_BUY ? bids.size() : asks.size()) >= DEPTH)
        begin
          add_expected(done_item(lobm_pkg::ST_FULL, rq.quantity, 1'b0));
        end else begin
          e.price = rq.limit_price;
          e.qty = rq.quantity;
          e.id = rq.order_id;
          book_insert(rq.side, e);
          while (bids.size() > 0 && asks.size() > 0 && bids[0].price >= asks[0].price) begin
            fill = bids[0].qty < asks[0].qty ? bids[0].qty : asks[0].qty;
            add_expected(trade_item(asks[0].price, fill, bids[0].id, asks[0].id));
            rem = rem >= fill ? rem - fill : '0;
            bids[0].qty -= fill;
            asks[0].qty -= fill;
            if (bids[0].qty == 0) void'(bids.pop_front());
            if (asks[0].qty == 0) void'(asks.pop_front());
          end
          add_expected(done_item(lobm_pkg::ST_OK, rem, 1'b0));
        end
      end
      lobm_pkg::ACT_MARKET: begin
        if (rq.side == lobm_pkg::SIDE_BUY) begin
          while (rem != 0 && asks.size() > 0) begin
            fill = rem < asks[0].qty ? rem : asks[0].qty;
            add_expected(trade_item(asks[0].price, fill, rq.order_id, asks[0].id));
            rem -= fill;
            asks[0].qty -= fill;
            if (asks[0].qty == 0) void'(asks.pop_front());
          end
        end else begin
          while (rem != 0 && bids.size() > 0) begin
            fill = rem < bids[0].qty ? rem : bids[0].qty;
            add_expected(trade_item(bids[0].price, fill, bids[0].id, rq.order_id));
            rem -= fill;
            bids[0].qty -= fill;
            if (bids[0].qty == 0) void'(bids.pop_front());
          end
        end
        add_expected(done_item(lobm_pkg::ST_OK, rem, 1'b0));
      end
      lobm_pkg::ACT_CANCEL: begin
        // Ask book is searched before the bid book; first match in book order.
        pos = -1;
        for (int i = 0; i < asks.size(); i++) begin
          if (pos < 0 && asks[i].id == rq.order_id) pos = i;
        end
        if (pos >= 0) begin
          asks.delete(pos);
          add_expected(done_item(lobm_pkg::ST_OK, '0, lobm_pkg::SIDE_SELL));
        end else begin
          for (int i = 0; i < bids.size(); i++) begin
            if (pos < 0 && bids[i].id == rq.order_id) pos = i;
          end
          if (pos >= 0) begin
            bids.delete(pos);
            add_expected(done_item(lobm_pkg::ST_OK, '0, lobm_pkg::SIDE_BUY));
          end else begin
            add_expected(done_item(lobm_pkg::ST_NOTFOUND, '0, 1'b0));
          end
        end
      end
      default: add_expected(done_item(lobm_pkg::ST_OK, '0, 1'b0));
    endcase
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------
  // Request driver: one request per handshake, random gaps between them.
  // --------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (req_ch.valid && !req_ch.ready) begin
      // hold the request until the block takes it
    end else begin
      if (req_ch.valid) begin
        // accepted at this edge
        match_request(pending_reqs.pop_front());
      end
      if (send_gap > 0) begin
        req_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        req_ch.valid       <= 1'b1;
        req_ch.action      <= pending_reqs[0].action;
        req_ch.side        <= pending_reqs[0].side;
        req_ch.limit_price <= pending_reqs[0].limit_price;
        req_ch.quantity    <= pending_reqs[0].quantity;
        req_ch.order_id    <= pending_reqs[0].order_id;
        send_gap <= pick_gap();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Note: the popped request above is the one shown on the bus, since the head
  // of pending_reqs is only removed when its handshake completes.

  // --------------------------------------------------------------------
  // Result monitor: random back-pressure, compare against oldest expectation.
  // --------------------------------------------------------------------
  int stall_left = 0;
  lobm_pkg::result_t got;
  lobm_pkg::result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got.kind          = res_ch.kind;
        got.trade_price   = res_ch.trade_price;
        got.trade_qty     = res_ch.trade_qty;
        got.buyer_id      = res_ch.buyer_id;
        got.seller_id     = res_ch.seller_id;
        got.status        = res_ch.status;
        got.remaining_qty = res_ch.remaining_qty;
        got.found_side    = res_ch.found_side;
        got.last          = res_ch.last;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", got));
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
          if (got.trade_price !== want.trade_price)
            report_mismatch($sformatf("trade_price %0d, want %0d",
                                      got.trade_price, want.trade_price));
          if (got.trade_qty !== want.trade_qty)
            report_mismatch($sformatf("trade_qty %0d, want %0d", got.trade_qty, want.trade_qty));
          if (got.buyer_id !== want.buyer_id)
            report_mismatch($sformatf("buyer_id %0d, want %0d", got.buyer_id, want.buyer_id));
          if (got.seller_id !== want.seller_id)
            report_mismatch($sformatf("seller_id %0d, want %0d", got.seller_id, want.seller_id));
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.remaining_qty !== want.remaining_qty)
            report_mismatch($sformatf("remaining_qty %0d, want %0d",
                                      got.remaining_qty, want.remaining_qty));
          if (got.found_side !== want.found_side)
            report_mismatch($sformatf("found_side %0d, want %0d",
                                      got.found_side, want.found_side));
          if (got.last !== want.last)
            report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
        end
      end
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        res_ch.ready <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------
  // Stimulus: directed corner cases, then random order flow.
  // --------------------------------------------------------------------
  function automatic request_t mk_req(input logic [1:0] act, input logic sd,
                                      input logic [DW-1:0] pr, input logic [DW-1:0] q,
                                      input logic [DW-1:0] oid);
    request_t r;
    r.action = act;
    r.side = sd;
    r.limit_price = pr;
    r.quantity = q;
    r.order_id = oid;
    return r;
  endfunction

  // Draw a price near a mid so books cross often, with rare extremes.
  function automatic logic [DW-1:0] pick_price();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 6) return '1;
    if (r < 12) return $urandom();
    return 1000 + $urandom_range(0, 20);
  endfunction

  function automatic logic [DW-1:0] pick_qty();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 10) return $urandom();
    if (r < 13) return '1;
    return $urandom_range(1, 50);
  endfunction

  initial begin
    request_t rq;
    int kind_pick;

    req_ch.valid = 1'b0;
    req_ch.action = lobm_pkg::ACT_ADD;
    req_ch.side = lobm_pkg::SIDE_BUY;
    req_ch.limit_price = '0;
    req_ch.quantity = '0;
    req_ch.order_id = '0;
    res_ch.ready = 1'b0;

    // Directed part.
    add_request(mk_req(lobm_pkg::ACT_ADD, lobm_pkg::SIDE_BUY, 100, 0, 1));      // zero qty add
    add_request(mk_req(lobm_pkg::ACT_MARKET, lobm_pkg::SIDE_BUY, 0, 10, 2));    // empty book
    add_request(mk_req(lobm_pkg::ACT_MARKET, lobm_pkg::SIDE_SELL, 0, 0, 3));    // zero qty
    add_request(mk_req(lobm_pkg::ACT_ADD, lobm_pkg::SIDE_BUY, 100, 5, 10));
    add_request(mk_req(lobm_pkg::ACT_ADD, lobm_pkg::SIDE_BUY, 100, 5, 10));     // same price, id
    add_request(mk_req(lobm_pkg::ACT_ADD, lobm_pkg::SIDE_BUY, 100, 7, 4));      // earlier id
    add_request(mk_req(lobm_pkg::ACT_ADD, lobm_pkg::SIDE_SELL, 90, 12, 20));    // crosses
    add_request(mk_req(lobm_pkg::ACT_ADD, lobm_pkg::SIDE_SELL, '1, '1, '1));    // max fields
    add_request(mk_req(lobm_pkg::ACT_ADD, lobm_pkg::SIDE_BUY, '0, '1, '0));     // min price
    add_request(mk_req(lobm_pkg::ACT_CANCEL, lobm_pkg::SIDE_BUY, 0, 0, '1));    // on ask side
    add_request(mk_req(lobm_pkg::ACT_CANCEL, lobm_pkg::SIDE_SELL, 0, 0, 10));   // on bid side
    add_request(mk_req(lobm_pkg::ACT_CANCEL, lobm_pkg::SIDE_BUY, 0, 0, 12345)); // not found
    add_request(mk_req(ACT_UNUSED, lobm_pkg::SIDE_SELL, '1, '1, '1));           // no meaning
    add_request(mk_req(lobm_pkg::ACT_MARKET, lobm_pkg::SIDE_SELL, 0, '1, 30));  // sweeps bids
    // Fill the ask book, then one more add is rejected as full.
    for (int i = 0; i < DEPTH + 1; i++)
      add_request(mk_req(lobm_pkg::ACT_ADD, lobm_pkg::SIDE_SELL, 2000 + i, 3, 100 + i));
    add_request(mk_req(lobm_pkg::ACT_MARKET, lobm_pkg::SIDE_BUY, 0, 100, 40));  // sweeps asks

    // Random order flow: mostly crossing adds and markets near a mid, some cancels
    // of ids likely live, and occasional noise.
    for (int n = 0; n < 330; n++) begin
      kind_pick = $urandom_range(0, 99);
      rq.side = 1'($urandom_range(0, 1));
      rq.limit_price = pick_price();
      rq.quantity = pick_qty();
      rq.order_id = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 63);
      if (kind_pick < 65) rq.action = lobm_pkg::ACT_ADD;
      else if (kind_pick < 78) rq.action = lobm_pkg::ACT_MARKET;
      else if (kind_pick < 96) rq.action = lobm_pkg::ACT_CANCEL;
      else rq.action = ACT_UNUSED;
      add_request(rq);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_reqs.size() == 0 && !req_ch.valid);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
